// ===== hdl/ptt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg: shared types for the periodic task timer table
// Request and response layouts, request codes, sequencer states.
// ----------------------------------------------------------------------------
package ptt_pkg;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_POLL = 2'd2,
        REQ_TIME = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t   req_type;
        logic [15:0] period;
        logic        in_interrupt;
    } req_t;

    typedef struct packed {
        logic [2:0]  slot_id;
        logic        add_ok;
        logic [7:0]  run_mask;
        logic [7:0]  irq_mask;
        logic [31:0] time_now;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } seq_state_t;

    localparam logic [7:0] PENDING_MAX = 8'd255;

endpackage
`default_nettype wire

// ===== hdl/periodic_task_timer_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_timer_table: table of periodic timer slots
// Add, tick, poll and time requests, handled by one slot sweep per request.
// ----------------------------------------------------------------------------
// Each request is taken in, then a single shared count/compare unit visits
// the slots in order, one slot per cycle, and then the response is posted
// into the output register. req_stall stays high from acceptance until the
// response is posted; a response that waits on rsp_stall does not hold back
// the next request's sweep, only its posting. An add claims the lowest free
// slot; slots are never released except by reset. time_now reports the tick
// count after the request, for every kind of request.
module periodic_task_timer_table
    import ptt_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic req_valid,
    output       logic req_stall,
    input  wire  req_t req_data,
    output       logic rsp_valid,
    input  wire  logic rsp_stall,
    output       rsp_t rsp_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // slot table: valid bits reset, the rest only meaningful once valid
    logic [NUM_SLOTS-1:0] slot_valid_reg;
    logic [15:0]          slot_period_reg  [NUM_SLOTS];
    logic [15:0]          slot_count_reg   [NUM_SLOTS];
    logic [7:0]           slot_pending_reg [NUM_SLOTS];
    logic                 slot_irq_reg     [NUM_SLOTS];

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      tick_time_reg, tick_time_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_data_reg, rsp_data_next;

    req_t             req_reg, req_next;
    logic             found_reg, found_next;
    logic [2:0]       sid_reg, sid_next;
    logic [7:0]       run_reg, run_next;
    logic [7:0]       fire_reg, fire_next;

    logic             accept;
    logic             post;
    logic             cur_valid;
    logic [15:0]      cur_period;
    logic [15:0]      cur_count;
    logic [7:0]       cur_pending;
    logic             cur_irq;
    logic [7:0]       cur_bit;

    logic             slot_wr;
    logic             valid_set;
    logic [15:0]      wr_period;
    logic [15:0]      wr_count;
    logic [7:0]       wr_pending;
    logic             wr_irq;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign post      = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign cur_valid   = slot_valid_reg[idx_reg];
    assign cur_period  = slot_period_reg[idx_reg];
    assign cur_count   = slot_count_reg[idx_reg];
    assign cur_pending = slot_pending_reg[idx_reg];
    assign cur_irq     = slot_irq_reg[idx_reg];
    // slots above seven have no mask bit: the shift runs off the end
    assign cur_bit     = 8'd1 << idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            tick_time_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tick_time_reg <= tick_time_next;
            rsp_valid_reg <= rsp_valid_next;
            if (valid_set)
            begin
                slot_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        found_reg    <= found_next;
        sid_reg      <= sid_next;
        run_reg      <= run_next;
        fire_reg     <= fire_next;
        rsp_data_reg <= rsp_data_next;
        if (slot_wr)
        begin
            slot_period_reg[idx_reg]  <= wr_period;
            slot_count_reg[idx_reg]   <= wr_count;
            slot_pending_reg[idx_reg] <= wr_pending;
            slot_irq_reg[idx_reg]     <= wr_irq;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tick_time_next = tick_time_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        req_next       = req_reg;
        found_next     = found_reg;
        sid_next       = sid_reg;
        run_next       = run_reg;
        fire_next      = fire_reg;
        slot_wr        = 1'b0;
        valid_set      = 1'b0;
        wr_period      = cur_period;
        wr_count       = cur_count;
        wr_pending     = cur_pending;
        wr_irq         = cur_irq;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req_data;
                    found_next = 1'b0;
                    sid_next   = '0;
                    run_next   = '0;
                    fire_next  = '0;
                    idx_next   = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                // shared slot unit: one slot per cycle
                case (req_reg.req_type)
                    REQ_TICK:
                    begin
                        if (cur_valid)
                        begin
                            slot_wr = 1'b1;
                            if (cur_count != 16'd0)
                            begin
                                wr_count = cur_count - 16'd1;
                            end
                            else
                            begin
                                wr_count = cur_period;
                                if (cur_pending != PENDING_MAX)
                                begin
                                    wr_pending = cur_pending + 8'd1;
                                end
                                if (cur_irq)
                                begin
                                    fire_next = fire_reg | cur_bit;
                                end
                            end
                        end
                    end
                    REQ_ADD:
                    begin
                        if (!cur_valid && !found_reg)
                        begin
                            slot_wr    = 1'b1;
                            valid_set  = 1'b1;
                            wr_period  = req_reg.period;
                            wr_count   = req_reg.period;
                            wr_pending = '0;
                            wr_irq     = req_reg.in_interrupt;
                            found_next = 1'b1;
                            sid_next   = 3'(idx_reg);
                        end
                    end
                    REQ_POLL:
                    begin
                        if (cur_valid && (cur_pending != 8'd0))
                        begin
                            slot_wr    = 1'b1;
                            wr_pending = '0;
                            if (!cur_irq)
                            begin
                                run_next = run_reg | cur_bit;
                            end
                        end
                    end
                    default:
                    begin
                        // time read leaves the table alone
                    end
                endcase

                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (post)
                begin
                    if (req_reg.req_type == REQ_TICK)
                    begin
                        tick_time_next = tick_time_reg + 32'd1;
                    end
                    rsp_data_next.slot_id  = sid_reg;
                    rsp_data_next.add_ok   = found_reg;
                    rsp_data_next.run_mask = run_reg;
                    rsp_data_next.irq_mask = fire_reg;
                    rsp_data_next.time_now = tick_time_next;
                    rsp_valid_next         = 1'b1;
                    idx_next               = '0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    // claimed slots stay claimed until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid_reg & $past(slot_valid_reg)) == $past(slot_valid_reg))
        else $error("slot valid bit cleared");

    // tick time moves only when a tick response is posted
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tick_time_reg) |->
            $past(post && (req_reg.req_type == REQ_TICK)))
        else $error("tick time changed outside a tick");

    // a poll response that names runnable slots carries no tick or add results
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.run_mask != 8'd0) |->
            (rsp_data.irq_mask == 8'd0) && !rsp_data.add_ok)
        else $error("poll response mixed with other results");

    // the sweep always starts from the first slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (idx_reg == '0))
        else $error("slot index not parked while idle");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the periodic task timer table
// A queue-fed driver sends tick, add, poll and time requests in bursts; a
// monitor stalls the response side on its own pattern and checks each
// response field by field against an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module testbench
    import ptt_pkg::*;
();

    localparam int SLOTS = 8;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    periodic_task_timer_table #(
        .NUM_SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data)
    );

    // request queue, filled by the sequence below
    req_t pending_reqs[$];
    // responses predicted for accepted requests, oldest first
    rsp_t expected_rsps[$];

    // model of the slot table
    bit          slot_used   [SLOTS];
    logic [15:0] slot_reload [SLOTS];
    logic [15:0] slot_left   [SLOTS];
    logic [7:0]  slot_hits   [SLOTS];
    bit          slot_irq    [SLOTS];
    logic [31:0] ticks_seen;

    int mismatches = 0;
    int rsp_checked = 0;
    int n_tick = 0;
    int n_add = 0;
    int n_refused = 0;
    int n_poll = 0;
    int n_time = 0;
    int n_saturated = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t predict_timer(req_t r);
        rsp_t rsp;
        bit claimed;
        rsp = '0;
        claimed = 1'b0;
        case (r.req_type)
            REQ_TICK:
            begin
                n_tick++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i])
                    begin
                        if (slot_left[i] != 16'd0)
                            slot_left[i] = slot_left[i] - 16'd1;
                        else
                        begin
                            slot_left[i] = slot_reload[i];
                            if (slot_hits[i] != PENDING_MAX)
                            begin
                                slot_hits[i] = slot_hits[i] + 8'd1;
                                if (slot_hits[i] == PENDING_MAX)
                                    n_saturated++;
                            end
                            if (slot_irq[i])
                                rsp.irq_mask[i] = 1'b1;
                        end
                    end
                end
                ticks_seen = ticks_seen + 32'd1;
            end
            REQ_ADD:
            begin
                n_add++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!claimed && !slot_used[i])
                    begin
                        claimed = 1'b1;
                        slot_used[i] = 1'b1;
                        slot_reload[i] = r.period;
                        slot_left[i] = r.period;
                        slot_hits[i] = 8'd0;
                        slot_irq[i] = r.in_interrupt;
                        rsp.slot_id = 3'(i);
                        rsp.add_ok = 1'b1;
                    end
                end
                if (!claimed)
                    n_refused++;
            end
            REQ_POLL:
            begin
                n_poll++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i] && slot_hits[i] != 8'd0)
                    begin
                        slot_hits[i] = 8'd0;
                        if (!slot_irq[i])
                            rsp.run_mask[i] = 1'b1;
                    end
                end
            end
            default:
                n_time++;
        endcase
        rsp.time_now = ticks_seen;
        return rsp;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_reload[i] = 16'd0;
                slot_left[i] = 16'd0;
                slot_hits[i] = 8'd0;
                slot_irq[i] = 1'b0;
            end
            ticks_seen = 32'd0;
        end
        else if (req_valid && !req_stall)
            expected_rsps.push_back(predict_timer(req_data));
    end

    // driver: bursts of requests with random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req_valid <= 1'b1;
                req_data <= pending_reqs.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    task automatic check_response(rsp_t got);
        rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            $error("response with no request outstanding: %h", got);
            mismatches++;
        end
        else
        begin
            want = expected_rsps.pop_front();
            rsp_checked++;
            if (got.slot_id !== want.slot_id)
            begin
                $error("slot_id: expected %0d, got %0d", want.slot_id, got.slot_id);
                mismatches++;
            end
            if (got.add_ok !== want.add_ok)
            begin
                $error("add_ok: expected %0b, got %0b", want.add_ok, got.add_ok);
                mismatches++;
            end
            if (got.run_mask !== want.run_mask)
            begin
                $error("run_mask: expected %h, got %h", want.run_mask, got.run_mask);
                mismatches++;
            end
            if (got.irq_mask !== want.irq_mask)
            begin
                $error("irq_mask: expected %h, got %h", want.irq_mask, got.irq_mask);
                mismatches++;
            end
            if (got.time_now !== want.time_now)
            begin
                $error("time_now: expected %0d, got %0d", want.time_now, got.time_now);
                mismatches++;
            end
        end
    endtask

    // monitor: checks responses and drives the response stall
    int rsp_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_window = 0;
    int stall_pct = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_response(rsp_data);
                rsp_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && rsp_seen >= 120)
            begin
                // long hold-off so the block backs up into its request side
                hold_done = 1'b1;
                hold_left = 300;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (stall_window == 0)
                begin
                    stall_window = $urandom_range(16, 96);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end
                stall_window--;
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic push_req(req_kind_t kind, logic [15:0] per, logic irq);
        req_t r;
        r.req_type = kind;
        r.period = per;
        r.in_interrupt = irq;
        pending_reqs.push_back(r);
    endtask

    // wait until every queued request is accepted and answered
    task automatic drain_all();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] noise_period();
        return 16'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: tick, poll and time read touch no slot
        push_req(REQ_TICK, 16'hFFFF, 1'b1);
        push_req(REQ_POLL, 16'h0000, 1'b0);
        push_req(REQ_TIME, 16'hFFFF, 1'b1);
        // fill the table, zero period and largest period among them
        push_req(REQ_ADD, 16'd0, 1'b0);
        push_req(REQ_ADD, 16'd0, 1'b1);
        push_req(REQ_ADD, 16'd1, 1'b1);
        push_req(REQ_ADD, 16'd2, 1'b0);
        push_req(REQ_ADD, 16'd3, 1'b1);
        push_req(REQ_ADD, 16'd5, 1'b0);
        push_req(REQ_ADD, 16'hFFFF, 1'b1);
        push_req(REQ_ADD, 16'd4, 1'b0);
        // table full
        push_req(REQ_ADD, 16'hFFFF, 1'b1);
        repeat (4) push_req(REQ_TICK, 16'd0, 1'b0);
        push_req(REQ_POLL, 16'hFFFF, 1'b1);
        repeat (3) push_req(REQ_TICK, 16'hA5A5, 1'b0);
        push_req(REQ_TIME, 16'd0, 1'b0);
        push_req(REQ_POLL, 16'd0, 1'b0);
        // nothing pending on a back-to-back poll
        push_req(REQ_POLL, 16'd0, 1'b1);
        push_req(REQ_TICK, 16'd0, 1'b1);
        push_req(REQ_POLL, 16'd0, 1'b0);
        drain_all();

        // long run of ticks with no poll so pending counts saturate
        for (int k = 0; k < 300; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_req(REQ_TIME, noise_period(), 1'($urandom_range(0, 1)));
            else
                push_req(REQ_TICK, noise_period(), 1'($urandom_range(0, 1)));
        end
        push_req(REQ_POLL, noise_period(), 1'($urandom_range(0, 1)));
        drain_all();

        // mixed traffic
        for (int k = 0; k < 200; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                push_req(REQ_TICK, noise_period(), 1'($urandom_range(0, 1)));
            else if (pick < 75)
                push_req(REQ_POLL, noise_period(), 1'($urandom_range(0, 1)));
            else if (pick < 85)
                push_req(REQ_TIME, noise_period(), 1'($urandom_range(0, 1)));
            else
                push_req(REQ_ADD, noise_period(), 1'($urandom_range(0, 1)));
        end
        drain_all();
        repeat (20) @(posedge clk);

        $display("checked %0d responses: %0d ticks, %0d adds (%0d refused),",
                 rsp_checked, n_tick, n_add, n_refused);
        $display("%0d polls, %0d time reads; pending count saturated %0d times",
                 n_poll, n_time, n_saturated);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d responses outstanding", expected_rsps.size());
        $display("FAILURE");
        $finish;
    end

endmodule
